@@ rtl/xrg_pkg.sv @@
// ----------------------------------------------------------------------------
// xrg_pkg: shared types and constants of the xoshiro range generator
// Holds the item mode codes, the SplitMix64 and xoshiro256** constants and
// the one-hot sequencer state type.
// ----------------------------------------------------------------------------
package xrg_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned HALF_W = WORD_W / 2;
  localparam int unsigned NUM_WORDS = 4;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [HALF_W-1:0] half_t;

  // Item mode codes
  localparam logic [1:0] MODE_SEED  = 2'd0;
  localparam logic [1:0] MODE_RAW   = 2'd1;
  localparam logic [1:0] MODE_RANGE = 2'd2;

  // SplitMix64 constants
  localparam word_t GOLDEN_STEP = 64'h9e3779b97f4a7c15;
  localparam word_t MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
  localparam word_t MIX_MUL_B   = 64'h94d049bb133111eb;

  // xoshiro256** constants
  localparam int unsigned XS_SHIFT = 17;
  localparam int unsigned XS_ROT   = 45;
  localparam int unsigned OUT_ROT  = 7;

  localparam word_t WORD_MAX = {WORD_W{1'b1}};

  // Sequencer states, one-hot
  typedef enum logic [10:0] {
    ST_IDLE    = 11'b000_0000_0001,
    ST_MIX_ADD = 11'b000_0000_0010,
    ST_MIX_X30 = 11'b000_0000_0100,
    ST_MIX_X27 = 11'b000_0000_1000,
    ST_MIX_X31 = 11'b000_0001_0000,
    ST_MUL     = 11'b000_0010_0000,
    ST_DRAW    = 11'b000_0100_0000,
    ST_MUL9    = 11'b000_1000_0000,
    ST_CHECK   = 11'b001_0000_0000,
    ST_DIV     = 11'b010_0000_0000,
    ST_DONE    = 11'b100_0000_0000
  } state_t;

endpackage

@@ rtl/xoshiro_range_generator.sv @@
// ----------------------------------------------------------------------------
// xoshiro_range_generator: xoshiro256** generator with SplitMix64 seeding
// Seed, raw and bounded draws run through one small sequencer that shares a
// 32x32 multiplier (seeding) and a bit-serial 64-bit divider (bounded draws).
// ----------------------------------------------------------------------------
// Steps: a seed item mixes each of the four state words in turn; a raw draw
//   steps the state, then scales, rotates and scales the output; a bound of 0/1 (or
//   mode three) answers zero; other bounds run a limit pass, raw draws until one is kept, then a modulo pass.
// Throughput: one transaction at a time, the next taken the cycle after the
//   result is raised; the bit-serial divider passes set the bounded-draw rate.
// Reset: rst is synchronous; after release the sequencer seeds the state from
//   a zero seed, holding in_stall high, then accepts transactions.
// ----------------------------------------------------------------------------
module xoshiro_range_generator
  import xrg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [63:0] seed_value,
  input  logic [63:0] range_max,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] value
);

  state_t state;

  // Generator state
  word_t gen_words [NUM_WORDS];

  // Current transaction
  logic [1:0] cur_mode;
  word_t      bound;
  word_t      limit;
  word_t      result;

  // Seeding
  word_t       acc;      // SplitMix64 counter
  word_t       mix;      // word being mixed
  logic [1:0]  word_idx; // state word being filled
  logic        init_seed; // seeding after reset, no result
  logic        mix_sel;  // 0: first multiply, 1: second multiply

  // Shared multiplier: low 64 bits of mix * constant in three partial products
  logic [1:0]  mul_phase;
  word_t       mul_acc;
  word_t       mul_const;
  half_t       mul_a;
  half_t       mul_b;
  word_t       mul_prod;
  word_t       mul_sum;

  // Raw draw
  word_t       draw;
  word_t       draw_rot;
  word_t       xs_mix;   // word 3 folded with word 1, before the rotate
  word_t       xs_rot;

  // Shared divider: restoring, one bit per cycle, remainder only
  word_t       dvd;
  word_t       rem;
  logic [5:0]  div_cnt;
  logic        div_pass; // 0: limit pass, 1: final modulo pass
  logic [64:0] rem_shift;
  logic [64:0] rem_diff;
  word_t       rem_next;

  // --------------------------------------------------------------------------
  // Datapath helpers
  // --------------------------------------------------------------------------
  assign mul_const = mix_sel ? MIX_MUL_B : MIX_MUL_A;
  assign mul_a     = (mul_phase == 2'd2) ? mix[WORD_W-1:HALF_W] : mix[HALF_W-1:0];
  assign mul_b     = (mul_phase == 2'd1) ? mul_const[WORD_W-1:HALF_W]
                                         : mul_const[HALF_W-1:0];
  assign mul_prod  = WORD_W'(mul_a) * WORD_W'(mul_b);
  // cross products land in the upper half only
  assign mul_sum   = mul_acc + {mul_prod[HALF_W-1:0], {HALF_W{1'b0}}};

  assign draw_rot  = {draw[WORD_W-1-OUT_ROT:0], draw[WORD_W-1:WORD_W-OUT_ROT]};

  assign xs_mix    = gen_words[3] ^ gen_words[1];
  assign xs_rot    = {xs_mix[WORD_W-1-XS_ROT:0], xs_mix[WORD_W-1:WORD_W-XS_ROT]};

  assign rem_shift = {rem, dvd[WORD_W-1]};
  assign rem_diff  = rem_shift - {1'b0, bound};
  // keep the difference when no borrow came out of the top bit
  assign rem_next  = rem_diff[WORD_W] ? rem_shift[WORD_W-1:0] : rem_diff[WORD_W-1:0];

  // Take a new transaction only while idle
  assign in_stall = (state != ST_IDLE);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_MIX_ADD;
      acc       <= '0;
      word_idx  <= '0;
      init_seed <= 1'b1;
      out_valid <= 1'b0;
      mix_sel   <= 1'b0;
      mul_phase <= '0;
      div_cnt   <= '0;
      div_pass  <= 1'b0;
      cur_mode  <= MODE_SEED;
    end else begin
      // drop the result once the consumer takes it, unless a new one lands now
      if (out_valid && !out_stall && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cur_mode <= mode;
            bound    <= range_max;
            unique case (mode)
              MODE_SEED: begin
                acc      <= seed_value;
                word_idx <= '0;
                state    <= ST_MIX_ADD;
              end
              MODE_RAW: begin
                state <= ST_DRAW;
              end
              MODE_RANGE: begin
                if (range_max <= WORD_W'(1)) begin
                  result <= '0;
                  state  <= ST_DONE;
                end else begin
                  // first pass: remainder of all-ones by bound gives the limit
                  dvd      <= WORD_MAX;
                  rem      <= '0;
                  div_cnt  <= '0;
                  div_pass <= 1'b0;
                  state    <= ST_DIV;
                end
              end
              default: begin
                // unused mode: answer zero, leave the state alone
                result <= '0;
                state  <= ST_DONE;
              end
            endcase
          end
        end

        ST_MIX_ADD: begin
          acc   <= acc + GOLDEN_STEP;
          mix   <= acc + GOLDEN_STEP;
          state <= ST_MIX_X30;
        end

        ST_MIX_X30: begin
          mix       <= mix ^ (mix >> 30);
          mix_sel   <= 1'b0;
          mul_phase <= '0;
          state     <= ST_MUL;
        end

        ST_MUL: begin
          unique case (mul_phase)
            2'd0: begin
              mul_acc   <= mul_prod;
              mul_phase <= 2'd1;
            end
            2'd1: begin
              mul_acc   <= mul_sum;
              mul_phase <= 2'd2;
            end
            default: begin
              mix   <= mul_sum;
              state <= mix_sel ? ST_MIX_X31 : ST_MIX_X27;
            end
          endcase
        end

        ST_MIX_X27: begin
          mix       <= mix ^ (mix >> 27);
          mix_sel   <= 1'b1;
          mul_phase <= '0;
          state     <= ST_MUL;
        end

        ST_MIX_X31: begin
          gen_words[word_idx] <= mix ^ (mix >> 31);
          if (word_idx == 2'(NUM_WORDS - 1)) begin
            if (init_seed) begin
              init_seed <= 1'b0;
              state     <= ST_IDLE;
            end else begin
              result <= '0;
              state  <= ST_DONE;
            end
          end else begin
            word_idx <= word_idx + 2'd1;
            state    <= ST_MIX_ADD;
          end
        end

        ST_DRAW: begin
          // output starts as word 1 times five; advance the state
          draw         <= gen_words[1] + (gen_words[1] << 2);
          gen_words[0] <= gen_words[0] ^ gen_words[3] ^ gen_words[1];
          gen_words[1] <= gen_words[1] ^ gen_words[2] ^ gen_words[0];
          gen_words[2] <= gen_words[2] ^ gen_words[0] ^ (gen_words[1] << XS_SHIFT);
          gen_words[3] <= xs_rot;
          state <= ST_MUL9;
        end

        ST_MUL9: begin
          draw  <= draw_rot + (draw_rot << 3);
          state <= ST_CHECK;
        end

        ST_CHECK: begin
          if (cur_mode == MODE_RAW) begin
            result <= draw;
            state  <= ST_DONE;
          end else if (draw >= limit) begin
            // reject and draw again
            state <= ST_DRAW;
          end else begin
            dvd      <= draw;
            rem      <= '0;
            div_cnt  <= '0;
            div_pass <= 1'b1;
            state    <= ST_DIV;
          end
        end

        ST_DIV: begin
          rem     <= rem_next;
          dvd     <= dvd << 1;
          div_cnt <= div_cnt + 6'd1;
          if (div_cnt == 6'(WORD_W - 1)) begin
            if (div_pass) begin
              result <= rem_next;
              state  <= ST_DONE;
            end else begin
              limit <= ~rem_next;
              state <= ST_DRAW;
            end
          end
        end

        ST_DONE: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            value     <= result;
            state     <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ test/tb_xoshiro_range_generator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_xoshiro_range_generator: self-checking bench for the xoshiro range block
// Runs a directed table of seed, raw and bounded draws, then about nine hundred
// random transactions. Every result is compared with an in-bench xoshiro256**
// and SplitMix64 predictor, under bursty input and a stalling output.
// ----------------------------------------------------------------------------
module tb_xoshiro_range_generator
  import xrg_pkg::*;
();

  // Mode three is not decoded by the block; it still returns one zero result
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam int unsigned RANDOM_ITEMS = 930;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned MAX_REPORTS  = 10;

  // One row of the directed table. When has_fixed is set the expected value is
  // the typed fixed_value; otherwise the predictor supplies it.
  typedef struct packed {
    logic [1:0] mode;
    word_t      seed;
    word_t      bound;
    logic       has_fixed;
    word_t      fixed_value;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  mode = MODE_SEED;
  logic [63:0] seed_value = '0;
  logic [63:0] range_max = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] value;

  // Predictor state: the four generator words as the block should hold them
  word_t xs_words [NUM_WORDS];

  // Values the block still owes, oldest first
  word_t pending_values [$];
  stim_row_t directed_rows [$];

  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned burst_left   = 0;

  xoshiro_range_generator i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .seed_value (seed_value),
    .range_max  (range_max),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .value      (value)
  );

  always begin
    #2;
    clk = 1'b1;
    #2;
    clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Advance the SplitMix64 accumulator and return its mixed output
  function automatic word_t splitmix_step(inout word_t acc);
    word_t v;
    acc = acc + GOLDEN_STEP;
    v = acc;
    v = (v ^ (v >> 30)) * MIX_MUL_A;
    v = (v ^ (v >> 27)) * MIX_MUL_B;
    return v ^ (v >> 31);
  endfunction

  function automatic void reseed_words(word_t seed);
    word_t acc;
    acc = seed;
    for (int i = 0; i < NUM_WORDS; i++) begin
      xs_words[i] = splitmix_step(acc);
    end
  endfunction

  function automatic word_t rotl64(word_t x, int unsigned k);
    return (x << k) | (x >> (WORD_W - k));
  endfunction

  // One xoshiro256** output; the state moves forward by one step
  function automatic word_t xoshiro_next();
    word_t scrambled;
    word_t shifted;
    scrambled = rotl64(xs_words[1] * 64'd5, OUT_ROT) * 64'd9;
    shifted = xs_words[1] << XS_SHIFT;
    xs_words[2] ^= xs_words[0];
    xs_words[3] ^= xs_words[1];
    xs_words[1] ^= xs_words[2];
    xs_words[0] ^= xs_words[3];
    xs_words[2] ^= shifted;
    xs_words[3] = rotl64(xs_words[3], XS_ROT);
    return scrambled;
  endfunction

  // Rejection sampling below the largest multiple of the bound
  function automatic word_t bounded_draw(word_t bound);
    word_t limit;
    word_t r;
    if (bound <= 64'd1) begin
      return '0;
    end
    limit = (WORD_MAX / bound) * bound;
    do begin
      r = xoshiro_next();
    end while (r >= limit);
    return r % bound;
  endfunction

  function automatic word_t predict_value(logic [1:0] m, word_t seed, word_t bound);
    case (m)
      MODE_SEED: begin
        reseed_words(seed);
        return '0;
      end
      MODE_RAW:   return xoshiro_next();
      MODE_RANGE: return bounded_draw(bound);
      default:    return '0;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Random field pickers
  // --------------------------------------------------------------------------

  function automatic word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  // Spread bounds over the classes that stress the limit and modulo paths
  function automatic word_t rand_bound();
    case ($urandom_range(0, 9))
      0:       return word_t'($urandom_range(0, 1));
      1:       return word_t'($urandom_range(2, 16));
      2:       return word_t'($urandom_range(2, 1000));
      3:       return word_t'(1) << $urandom_range(1, 63);
      // at or just above 2^63: close to half of all draws get rejected
      4:       return {1'b1, 47'd0, 16'($urandom)};
      5:       return rand_word();
      6:       return rand_word() >> $urandom_range(1, 62);
      7:       return WORD_MAX - word_t'($urandom_range(0, 255));
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic word_t rand_seed();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return WORD_MAX;
      default: return rand_word();
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Sender: offer one transaction, hold it until accepted, then predict.
  // Bursts of random length are separated by random idle gaps.
  // --------------------------------------------------------------------------
  task automatic offer_item(input logic [1:0] m, input word_t seed, input word_t bound,
                            input logic has_fixed, input word_t fixed_value);
    word_t predicted;
    mode       <= m;
    seed_value <= seed;
    range_max  <= bound;
    in_valid   <= 1'b1;
    do begin
      @(posedge clk);
    end while (in_stall);
    // Always step the predictor so its state tracks the block, even for rows
    // whose expectation is typed into the table
    predicted = predict_value(m, seed, bound);
    pending_values.push_back(has_fixed ? fixed_value : predicted);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
  endtask

  // --------------------------------------------------------------------------
  // Checker
  // --------------------------------------------------------------------------
  function automatic void note_failure(string what, word_t expected_value, word_t actual_value);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t: %s: expected %h, got %h", $realtime, what, expected_value, actual_value);
    end
  endfunction

  // Sample the output handshake; out_stall read here is the value the block saw
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_values.size() == 0) begin
        note_failure("unexpected result", '0, value);
      end else if (value !== pending_values[0]) begin
        note_failure("value mismatch", pending_values[0], value);
        void'(pending_values.pop_front());
      end else begin
        void'(pending_values.pop_front());
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall on a pattern of its own. Each stretch picks no stalls,
  // light stalls or heavy stalls. Twice in the run, hold off completely for a
  // long stretch so the block fills up and pushes back on its input.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int unsigned next_hold_at;
    int unsigned pattern;
    int unsigned stretch;
    next_hold_at = 80;
    while (rst) @(posedge clk);
    forever begin
      if (results_seen >= next_hold_at) begin
        @(posedge clk);
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        next_hold_at = (next_hold_at < 500) ? 500 : 32'hffff_ffff;
      end
      pattern = $urandom_range(0, 2);
      stretch = $urandom_range(10, 80);
      repeat (stretch) begin
        @(posedge clk);
        case (pattern)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Run limit: well beyond the slowest legal run (~950 items, bounded draws with
  // rejections, full output stalls and sender gaps, plus the seeding after reset)
  // --------------------------------------------------------------------------
  initial begin : run_limit
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int unsigned counted;
    logic [1:0] m;
    int unsigned pick;

    // After reset the block holds the words of a zero seed
    reseed_words('0);

    // Directed table: mode, seed, bound, typed flag, typed value
    directed_rows.push_back({MODE_RANGE, 64'd0, 64'd0, 1'b1, 64'd0});
    directed_rows.push_back({MODE_RAW, 64'd0, 64'd0, 1'b0, 64'd0});
    directed_rows.push_back({MODE_RAW, WORD_MAX, WORD_MAX, 1'b0, 64'd0});
    directed_rows.push_back({MODE_RANGE, 64'd0, 64'd1, 1'b1, 64'd0});
    directed_rows.push_back({MODE_UNUSED, WORD_MAX, WORD_MAX, 1'b1, 64'd0});
    directed_rows.push_back({MODE_RANGE, 64'd0, 64'd2, 1'b0, 64'd0});
    directed_rows.push_back({MODE_RANGE, 64'd0, WORD_MAX, 1'b0, 64'd0});
    directed_rows.push_back({MODE_RANGE, 64'd0, 64'h8000_0000_0000_0000, 1'b0, 64'd0});
    directed_rows.push_back({MODE_RANGE, 64'd0, 64'h8000_0000_0000_0001, 1'b0, 64'd0});
    directed_rows.push_back({MODE_RANGE, 64'd0, 64'd3, 1'b0, 64'd0});
    directed_rows.push_back({MODE_SEED, 64'd0, 64'd0, 1'b1, 64'd0});
    directed_rows.push_back({MODE_RAW, 64'd0, 64'd0, 1'b0, 64'd0});
    directed_rows.push_back({MODE_SEED, WORD_MAX, WORD_MAX, 1'b1, 64'd0});
    directed_rows.push_back({MODE_RAW, 64'd0, 64'd0, 1'b0, 64'd0});
    directed_rows.push_back({MODE_RANGE, 64'd0, 64'd1000, 1'b0, 64'd0});
    directed_rows.push_back({MODE_SEED, 64'h0123_4567_89ab_cdef, 64'd0, 1'b1, 64'd0});
    directed_rows.push_back({MODE_RANGE, 64'd0, 64'h0000_0001_0000_0000, 1'b0, 64'd0});
    directed_rows.push_back({MODE_UNUSED, 64'd0, 64'd0, 1'b1, 64'd0});
    directed_rows.push_back({MODE_RAW, 64'd0, 64'd0, 1'b0, 64'd0});
    directed_rows.push_back({MODE_RANGE, 64'd0, 64'd10, 1'b0, 64'd0});

    // Hold reset, then release; the block seeds its state with in_stall high
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      offer_item(directed_rows[i].mode, directed_rows[i].seed, directed_rows[i].bound,
                 directed_rows[i].has_fixed, directed_rows[i].fixed_value);
    end

    // Random part: mostly draws, some reseeds, a few mode-three items
    // that do not count toward the total
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        m = MODE_SEED;
      end else if (pick < 40) begin
        m = MODE_RAW;
      end else if (pick < 96) begin
        m = MODE_RANGE;
      end else begin
        m = MODE_UNUSED;
      end
      offer_item(m, rand_seed(), rand_bound(), 1'b0, '0);
      if (m != MODE_UNUSED) begin
        counted++;
      end
    end

    // Drop valid unless the last gap already did, then drain
    if (in_valid) begin
      in_valid <= 1'b0;
    end
    while (pending_values.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_values.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
